### rtl/rau_pkg.sv
package rau_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int OUT_WIDTH = 34;
    localparam int OP_WIDTH  = 3;

    localparam logic [OP_WIDTH-1:0] OP_ADD = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_CMP = 3'd4;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    typedef enum logic [2:0] {
        K_ADD,
        K_SUB,
        K_MUL,
        K_DIV,
        K_CMP,
        K_NONE
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [IN_WIDTH-1:0] a_num;
        logic [IN_WIDTH-1:0] a_den;
        logic [IN_WIDTH-1:0] b_num;
        logic [IN_WIDTH-1:0] b_den;
    } t_item;

endpackage

### rtl/rau_front.sv
module rau_front
    import rau_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [OP_WIDTH-1:0] i_operation,
    input  logic [IN_WIDTH-1:0] i_a_num,
    input  logic [IN_WIDTH-1:0] i_a_den,
    input  logic [IN_WIDTH-1:0] i_b_num,
    input  logic [IN_WIDTH-1:0] i_b_den,
    output logic                o_item_valid,
    output t_item               o_item,
    input  logic                i_item_pop
);

    t_item       r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    t_kind       kind;
    t_item       item;
    logic        wr_fire;
    logic        rd_fire;

    always_comb begin
        unique case (i_operation)
            OP_ADD:  kind = K_ADD;
            OP_SUB:  kind = K_SUB;
            OP_MUL:  kind = K_MUL;
            OP_DIV:  kind = K_DIV;
            OP_CMP:  kind = K_CMP;
            default: kind = K_NONE;
        endcase
    end

    assign item = '{kind: kind, a_num: i_a_num, a_den: i_a_den,
                    b_num: i_b_num, b_den: i_b_den};

    assign full         = (r_cnt == 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rd];
    assign wr_fire      = push && !full;
    assign rd_fire      = i_item_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_fire) begin
                r_q[r_wr] <= item;
                r_wr      <= !r_wr;
            end
            if (rd_fire) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(wr_fire) - 2'(rd_fire);
        end
    end

endmodule

### rtl/rau_div.sv
module rau_div #(
    parameter int CW = 33
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [CW-1:0] o_quo,
    output logic [CW-1:0] o_rem
);

    localparam int CNTW = $clog2(CW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [CW-1:0]   r_rem;
    logic [CW-1:0]   r_quo;
    logic [CW-1:0]   r_div;
    logic [CW:0]     sh;
    logic [CW:0]     diff;

    // One quotient bit per cycle, restoring form.
    assign sh   = {r_rem, r_quo[CW-1]};
    assign diff = sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(CW);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!diff[CW]) begin
                    r_rem <= diff[CW-1:0];
                    r_quo <= {r_quo[CW-2:0], 1'b1};
                end else begin
                    r_rem <= sh[CW-1:0];
                    r_quo <= {r_quo[CW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

### rtl/rau_back.sv
module rau_back
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  t_item                 i_item,
    output logic                  o_item_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic [OUT_WIDTH-1:0]  o_result_num,
    output logic [OUT_WIDTH-1:0]  o_result_den,
    output logic [1:0]            o_order
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = 2 * W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_GCD_CHK,
        S_GCD_DIV,
        S_GDONE,
        S_DIVP,
        S_DIVQ,
        S_WB,
        S_MUL,
        S_COMB,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [1:0]            r_phase;
    logic [1:0]            r_mstep;
    t_kind                 r_kind;
    logic signed [CW-1:0]  r_an, r_ad, r_bn, r_bd, r_rn, r_rd;
    logic signed [CW-1:0]  r_p, r_q, r_gx, r_gy;
    logic signed [CW-1:0]  r_m0, r_m1, r_m2;
    logic [1:0]            r_ord;
    logic                  r_out_valid;
    logic [OUT_WIDTH-1:0]  r_out_num, r_out_den;
    logic [1:0]            r_out_ord;

    logic                  div_start;
    logic [CW-1:0]         div_a, div_b;
    logic                  div_done;
    logic [CW-1:0]         div_quo, div_rem;
    logic signed [W-1:0]   mul_a, mul_b;
    logic signed [2*W-1:0] prod;
    logic signed [CW-1:0]  sel_p, sel_q;
    logic signed [CW-1:0]  rem_s;
    logic signed [CW-1:0]  quo_s;
    logic signed [63:0]    rn64, rd64;
    logic                  out_free;
    logic                  g_trivial;

    function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    // Only the low operand bits of a 16-bit field count; above 16 it is zero-filled.
    function automatic logic signed [CW-1:0] sext_in(input logic [IN_WIDTH-1:0] raw);
        logic [W-1:0] low;
        low = W'(32'(raw));
        return CW'(signed'(low));
    endfunction

    rau_div #(.CW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    assign g_trivial = (r_gx == CW'(1)) || (r_gx == -CW'(1)) || (r_gx == '0);

    always_comb begin
        div_start = 1'b0;
        div_a     = mag(r_p);
        div_b     = mag(r_gx);
        case (r_state)
            S_GCD_CHK: begin
                div_start = (r_gy != '0);
                div_a     = mag(r_gx);
                div_b     = mag(r_gy);
            end
            S_GDONE: begin
                div_start = !g_trivial;
            end
            S_DIVP: begin
                div_start = div_done;
                div_a     = mag(r_q);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_phase)
            2'd0:    begin sel_p = r_an; sel_q = r_ad; end
            2'd1:    begin sel_p = r_bn; sel_q = r_bd; end
            default: begin sel_p = r_rn; sel_q = r_rd; end
        endcase
    end

    // C remainder takes the dividend's sign.
    assign rem_s = r_gx[CW-1] ? -signed'(div_rem) : signed'(div_rem);

    // Sign of an exact quotient: dividend sign xor divisor sign.
    always_comb begin
        if (r_state == S_DIVP) begin
            quo_s = (r_p[CW-1] ^ r_gx[CW-1]) ? -signed'(div_quo) : signed'(div_quo);
        end else begin
            quo_s = (r_q[CW-1] ^ r_gx[CW-1]) ? -signed'(div_quo) : signed'(div_quo);
        end
    end

    always_comb begin
        case (r_mstep)
            2'd0: begin
                mul_a = r_an[W-1:0];
                mul_b = (r_kind == K_MUL) ? r_bn[W-1:0] : r_bd[W-1:0];
            end
            2'd1: begin
                mul_a = r_bn[W-1:0];
                mul_b = r_ad[W-1:0];
            end
            default: begin
                mul_a = r_ad[W-1:0];
                mul_b = (r_kind == K_DIV) ? r_bn[W-1:0] : r_bd[W-1:0];
            end
        endcase
    end

    assign prod       = mul_a * mul_b;
    assign out_free   = !r_out_valid || pop;
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;
    assign rn64       = 64'(r_rn);
    assign rd64       = 64'(r_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_phase     <= 2'd0;
            r_mstep     <= 2'd0;
        end else begin
            // In S_OUT the output register is refilled instead.
            if (pop && r_out_valid && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_kind  <= i_item.kind;
                        r_an    <= sext_in(i_item.a_num);
                        r_ad    <= sext_in(i_item.a_den);
                        r_bn    <= sext_in(i_item.b_num);
                        r_bd    <= sext_in(i_item.b_den);
                        r_rn    <= '0;
                        r_rd    <= '0;
                        r_ord   <= ORD_LESS;
                        r_phase <= 2'd0;
                        r_state <= (i_item.kind == K_NONE) ? S_OUT : S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_p     <= sel_p;
                    r_q     <= sel_q;
                    r_gx    <= sel_p;
                    r_gy    <= sel_q;
                    r_state <= S_GCD_CHK;
                end
                S_GCD_CHK: begin
                    r_state <= (r_gy == '0) ? S_GDONE : S_GCD_DIV;
                end
                S_GCD_DIV: begin
                    if (div_done) begin
                        r_gx    <= r_gy;
                        r_gy    <= rem_s;
                        r_state <= S_GCD_CHK;
                    end
                end
                S_GDONE: begin
                    r_state <= g_trivial ? S_WB : S_DIVP;
                end
                S_DIVP: begin
                    if (div_done) begin
                        r_p     <= quo_s;
                        r_state <= S_DIVQ;
                    end
                end
                S_DIVQ: begin
                    if (div_done) begin
                        r_q     <= quo_s;
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    case (r_phase)
                        2'd0: begin
                            r_an    <= r_p;
                            r_ad    <= r_q;
                            r_phase <= 2'd1;
                            r_state <= S_LOAD;
                        end
                        2'd1: begin
                            r_bn    <= r_p;
                            r_bd    <= r_q;
                            r_mstep <= 2'd0;
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_rn    <= r_p;
                            r_rd    <= r_q;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_MUL: begin
                    case (r_mstep)
                        2'd0:    r_m0 <= CW'(prod);
                        2'd1:    r_m1 <= CW'(prod);
                        default: r_m2 <= CW'(prod);
                    endcase
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == 2'd2) begin
                        r_state <= S_COMB;
                    end
                end
                S_COMB: begin
                    r_phase <= 2'd2;
                    if (r_kind == K_CMP) begin
                        r_rn    <= '0;
                        r_rd    <= '0;
                        r_ord   <= (r_m0 < r_m1) ? ORD_LESS :
                                   ((r_m0 == r_m1) ? ORD_EQUAL : ORD_GREATER);
                        r_state <= S_OUT;
                    end else begin
                        r_rd    <= r_m2;
                        r_state <= S_LOAD;
                        case (r_kind)
                            K_ADD:   r_rn <= r_m0 + r_m1;
                            K_SUB:   r_rn <= r_m0 - r_m1;
                            default: r_rn <= r_m0;
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_num   <= rn64[OUT_WIDTH-1:0];
                        r_out_den   <= rd64[OUT_WIDTH-1:0];
                        r_out_ord   <= r_ord;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign empty        = !r_out_valid;
    assign o_result_num = r_out_num;
    assign o_result_den = r_out_den;
    assign o_order      = r_out_ord;

endmodule

### rtl/rational_arithmetic_unit.sv
// Each fraction is reduced by Euclid remainder steps and then exact divisions: both
// operands, and the result too except for a compare.
// All remainders and quotients share one radix-2 divider, which sets the rate.
// Throughput: one word at a time in the back end; a two-entry input queue and
// an output register let both sides keep moving. Synchronous active-low reset
// empties the queue and the output register.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [OP_WIDTH-1:0]  i_operation,
    input  logic [IN_WIDTH-1:0]  i_a_num,
    input  logic [IN_WIDTH-1:0]  i_a_den,
    input  logic [IN_WIDTH-1:0]  i_b_num,
    input  logic [IN_WIDTH-1:0]  i_b_den,
    output logic                 empty,
    input  logic                 pop,
    output logic [OUT_WIDTH-1:0] o_result_num,
    output logic [OUT_WIDTH-1:0] o_result_den,
    output logic [1:0]           o_order
);

    logic  item_valid;
    logic  item_pop;
    t_item item;

    rau_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_a_num      (i_a_num),
        .i_a_den      (i_a_den),
        .i_b_num      (i_b_num),
        .i_b_den      (i_b_den),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    rau_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .pop          (pop),
        .empty        (empty),
        .o_result_num (o_result_num),
        .o_result_den (o_result_den),
        .o_order      (o_order)
    );

endmodule

### rtl/rau_checker.sv
module rau_checker
    import rau_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 push,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input logic [OUT_WIDTH-1:0] o_result_num,
    input logic [OUT_WIDTH-1:0] o_result_den,
    input logic [1:0]           o_order
);

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result_num) && $stable(o_order)))
        else $error("waiting result changed before pop");

    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_order != 2'd3))
        else $error("order code out of range");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_order != ORD_LESS) |-> (o_result_num == '0 && o_result_den == '0))
        else $error("compare result carries a fraction");

    a_full_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("queue filled without a push");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_result_num (o_result_num),
    .o_result_den (o_result_den),
    .o_order      (o_order)
);

### bench/rational_arithmetic_unit_test.sv
module rational_arithmetic_unit_test;
    import rau_pkg::*;

    localparam logic [OP_WIDTH-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_WIDTH-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_WIDTH-1:0] OP_SPARE7 = 3'd7;
    localparam int RANDOM_PER_MODE = 445;
    localparam int DRAIN_CYCLES = 4000;

    typedef struct {
        logic [OUT_WIDTH-1:0] num;
        logic [OUT_WIDTH-1:0] den;
        logic [1:0]           ord;
    } t_fraction_result;

    typedef struct {
        logic [OP_WIDTH-1:0] op;
        logic [IN_WIDTH-1:0] an, ad, bn, bd;
        bit                  known;
        t_fraction_result    res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 pop = 1'b0;
    logic                 full, empty;
    logic [OP_WIDTH-1:0]  i_operation = '0;
    logic [IN_WIDTH-1:0]  i_a_num = '0, i_a_den = '0, i_b_num = '0, i_b_den = '0;
    logic [OUT_WIDTH-1:0] o_result_num, o_result_den;
    logic [1:0]           o_order;

    t_fraction_result pending_results[$];
    t_fraction_result offered_result;
    int  failures = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  tx_idle_pct = 19;
    int  rx_idle_pct = 53;
    int  stall_request = 0;

    rational_arithmetic_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // Euclid with truncating remainder; the divisor is skipped for 1, -1 and 0.
    function automatic void reduce_pair(inout longint num, inout longint den);
        longint x, y, t;
        x = num;
        y = den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x != 1 && x != -1 && x != 0) begin
            num = num / x;
            den = den / x;
        end
    endfunction

    function automatic t_fraction_result fraction_outcome(logic [OP_WIDTH-1:0] op,
            logic [IN_WIDTH-1:0] a_n, logic [IN_WIDTH-1:0] a_d,
            logic [IN_WIDTH-1:0] b_n, logic [IN_WIDTH-1:0] b_d);
        t_fraction_result r;
        longint an, ad, bn, bd, rn, rd, lhs, rhs;
        an = longint'($signed(a_n));
        ad = longint'($signed(a_d));
        bn = longint'($signed(b_n));
        bd = longint'($signed(b_d));
        rn = 0;
        rd = 0;
        r.ord = ORD_LESS;
        reduce_pair(an, ad);
        reduce_pair(bn, bd);
        case (op)
            OP_ADD: begin
                rn = an * bd + bn * ad;
                rd = ad * bd;
                reduce_pair(rn, rd);
            end
            OP_SUB: begin
                rn = an * bd - bn * ad;
                rd = ad * bd;
                reduce_pair(rn, rd);
            end
            OP_MUL: begin
                rn = an * bn;
                rd = ad * bd;
                reduce_pair(rn, rd);
            end
            OP_DIV: begin
                rn = an * bd;
                rd = ad * bn;
                reduce_pair(rn, rd);
            end
            OP_CMP: begin
                lhs = an * bd;
                rhs = bn * ad;
                r.ord = (lhs < rhs) ? ORD_LESS : ((lhs == rhs) ? ORD_EQUAL : ORD_GREATER);
            end
            default: ;
        endcase
        r.num = rn[OUT_WIDTH-1:0];
        r.den = rd[OUT_WIDTH-1:0];
        return r;
    endfunction

    // Drives one word and returns once it has been accepted.
    task automatic send_word(logic [OP_WIDTH-1:0] op, logic [IN_WIDTH-1:0] an,
            logic [IN_WIDTH-1:0] ad, logic [IN_WIDTH-1:0] bn, logic [IN_WIDTH-1:0] bd,
            bit known, t_fraction_result typed);
        bit taken;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if ($urandom_range(99) < tx_idle_pct) begin
                push <= 1'b0;
            end else begin
                push        <= 1'b1;
                i_operation <= op;
                i_a_num     <= an;
                i_a_den     <= ad;
                i_b_num     <= bn;
                i_b_den     <= bd;
                // Full only moves at the rising edge, so its value now decides acceptance.
                taken = !full;
            end
        end
        @(posedge i_clk);
        pending_results.push_back(known ? typed : fraction_outcome(op, an, ad, bn, bd));
        words_sent++;
    endtask

    function automatic logic [IN_WIDTH-1:0] random_operand();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            0:       return IN_WIDTH'($urandom_range(2, 0) == 0 ? 16'h8000 : 16'h7fff);
            1:       return '0;
            2, 3:    return IN_WIDTH'($signed($urandom_range(20)) - 10);
            4, 5:    return IN_WIDTH'(($signed($urandom_range(200)) - 100)
                                      * (1 << $urandom_range(6)));
            default: return IN_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [OP_WIDTH-1:0] random_op();
        return ($urandom_range(19) == 0) ? OP_WIDTH'($urandom_range(7, 5))
                                         : OP_WIDTH'($urandom_range(4));
    endfunction

    // Receiver: random pops, plus a long hold-off whenever one is requested.
    initial begin : receiver
        int hold_left, stalls_seen;
        hold_left = 0;
        stalls_seen = 0;
        forever begin
            @(negedge i_clk);
            if (stall_request != stalls_seen) begin
                stalls_seen = stall_request;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word num=%0d den=%0d order=%0d", $time,
                         $signed(o_result_num), $signed(o_result_den), o_order);
                failures++;
            end else begin
                offered_result = pending_results.pop_front();
                words_checked++;
                if (o_result_num !== offered_result.num) begin
                    $display("%0t: result_num expected %0d actual %0d", $time,
                             $signed(offered_result.num), $signed(o_result_num));
                    failures++;
                end
                if (o_result_den !== offered_result.den) begin
                    $display("%0t: result_den expected %0d actual %0d", $time,
                             $signed(offered_result.den), $signed(o_result_den));
                    failures++;
                end
                if (o_order !== offered_result.ord) begin
                    $display("%0t: order expected %0d actual %0d", $time,
                             offered_result.ord, o_order);
                    failures++;
                end
            end
        end
    end

    initial begin : limit
        #200000000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        t_row rows[] = '{
            '{OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 1'b0, '{0, 0, 0}},
            '{OP_SUB, 16'd1, 16'd2, 16'd1, 16'd3, 1'b0, '{0, 0, 0}},
            '{OP_MUL, -16'sd4, 16'd6, 16'd9, -16'sd8, 1'b0, '{0, 0, 0}},
            '{OP_DIV, 16'd3, 16'd4, -16'sd5, 16'd7, 1'b0, '{0, 0, 0}},
            '{OP_CMP, 16'd1, 16'd2, 16'd2, 16'd4, 1'b1, '{0, 0, ORD_EQUAL}},
            '{OP_CMP, 16'd1, 16'd3, 16'd1, 16'd2, 1'b1, '{0, 0, ORD_LESS}},
            '{OP_CMP, 16'd1, 16'd2, 16'd1, 16'd3, 1'b1, '{0, 0, ORD_GREATER}},
            '{OP_ADD, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, '{0, 0, 0}},
            '{OP_MUL, 16'd5, 16'd0, 16'd1, 16'd1, 1'b1, '{1, 0, 0}},
            '{OP_DIV, 16'd2, 16'd3, 16'd0, 16'd5, 1'b0, '{0, 0, 0}},
            '{OP_SUB, -16'sd7, 16'd0, 16'd3, 16'd0, 1'b0, '{0, 0, 0}},
            '{OP_SPARE5, 16'd1, 16'd2, 16'd3, 16'd4, 1'b1, '{0, 0, 0}},
            '{OP_SPARE6, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, '{0, 0, 0}},
            '{OP_SPARE7, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1, '{0, 0, 0}},
            '{OP_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0, '{0, 0, 0}},
            '{OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, '{0, 0, 0}},
            '{OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h0001, 1'b0, '{0, 0, 0}},
            '{OP_DIV, 16'h7fff, 16'h0001, 16'h0001, 16'h7fff, 1'b0, '{0, 0, 0}},
            '{OP_CMP, 16'h8000, 16'h0001, 16'h7fff, 16'h0001, 1'b1, '{0, 0, ORD_LESS}},
            '{OP_ADD, 16'd17711, 16'd28657, 16'd10946, 16'd17711, 1'b0, '{0, 0, 0}},
            '{OP_DIV, 16'h8000, 16'h7ffe, 16'h7ffd, 16'h8001, 1'b0, '{0, 0, 0}},
            '{OP_CMP, -16'sd1, 16'd0, 16'd1, 16'd0, 1'b0, '{0, 0, 0}}
        };
        t_fraction_result unused;
        int mode, n, drain;
        unused = '{0, 0, 0};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k])
            send_word(rows[k].op, rows[k].an, rows[k].ad, rows[k].bn, rows[k].bd,
                      rows[k].known, rows[k].res);

        for (mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 19 : ((mode == 1) ? 53 : 0);
            rx_idle_pct = (mode == 0) ? 53 : ((mode == 1) ? 19 : 0);
            for (n = 0; n < RANDOM_PER_MODE; n++) begin
                // Hold the receiver off long enough for the block to fill and stall.
                if (mode == 2 && n == 20)
                    stall_request++;
                // Let the block drain completely before carrying on.
                if (mode == 1 && n == 100) begin
                    @(negedge i_clk);
                    push <= 1'b0;
                    wait (pending_results.size() == 0);
                end
                send_word(random_op(), random_operand(), random_operand(),
                          random_operand(), random_operand(), 1'b0, unused);
            end
        end

        @(negedge i_clk);
        push <= 1'b0;
        wait (pending_results.size() == 0);
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge i_clk);

        $display("Sent %0d words over all five operations and the spare codes,", words_sent);
        $display("with zero denominators, extremes and stalls on both sides; %0d checked.",
                 words_checked);
        if (failures == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
